[hdl/exlex_pkg.sv]
// Shared types, token and mode codes and character classes for the expression lexer.
package exlex_pkg;

   localparam int POS_WIDTH_DEFAULT = 16;
   localparam int OUT_W             = 16;
   localparam int FIFO_DEPTH        = 4;

   // Lexer modes
   localparam logic [2:0] MODE_IDLE  = 3'd0;
   localparam logic [2:0] MODE_INT   = 3'd1;
   localparam logic [2:0] MODE_FLOAT = 3'd2;
   localparam logic [2:0] MODE_SYM   = 3'd3;
   localparam logic [2:0] MODE_EQ    = 3'd4;

   // Token kinds
   localparam logic [3:0] KIND_INT    = 4'd0;
   localparam logic [3:0] KIND_FLOAT  = 4'd1;
   localparam logic [3:0] KIND_PLUS   = 4'd2;
   localparam logic [3:0] KIND_MINUS  = 4'd3;
   localparam logic [3:0] KIND_LPAR   = 4'd4;
   localparam logic [3:0] KIND_RPAR   = 4'd5;
   localparam logic [3:0] KIND_MULT   = 4'd6;
   localparam logic [3:0] KIND_DIV    = 4'd7;
   localparam logic [3:0] KIND_EXP    = 4'd8;
   localparam logic [3:0] KIND_MOD    = 4'd9;
   localparam logic [3:0] KIND_EQ     = 4'd10;
   localparam logic [3:0] KIND_ASSIGN = 4'd11;
   localparam logic [3:0] KIND_SYM    = 4'd12;
   localparam logic [3:0] KIND_COMMA  = 4'd13;
   localparam logic [3:0] KIND_ERR    = 4'd14;
   localparam logic [3:0] KIND_END    = 4'd15;

   // Characters
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_EQUAL = 8'h3D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_CARET = 8'h5E;
   localparam logic [7:0] CH_PCENT = 8'h25;
   localparam logic [7:0] CH_LPAR  = 8'h28;
   localparam logic [7:0] CH_RPAR  = 8'h29;
   localparam logic [7:0] CH_COMMA = 8'h2C;

   typedef struct packed {
      logic [7:0] ch;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [3:0]       token_kind;
      logic [OUT_W-1:0] token_start;
      logic [OUT_W-1:0] token_length;
      logic             last_of_run;
   } rsp_type;

   // Results of one request, pushed into the result buffer together
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

   function automatic logic char_digit(input logic [7:0] c);
      return c inside {[8'h30:8'h39]};
   endfunction

   function automatic logic char_letter(input logic [7:0] c);
      return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
   endfunction

   function automatic logic [3:0] op_kind(input logic [7:0] c);
      logic [3:0] k;
      case (c)
         CH_PLUS:  k = KIND_PLUS;
         CH_MINUS: k = KIND_MINUS;
         CH_STAR:  k = KIND_MULT;
         CH_SLASH: k = KIND_DIV;
         CH_CARET: k = KIND_EXP;
         CH_PCENT: k = KIND_MOD;
         CH_LPAR:  k = KIND_LPAR;
         CH_RPAR:  k = KIND_RPAR;
         CH_COMMA: k = KIND_COMMA;
         default:  k = KIND_ERR;
      endcase
      return k;
   endfunction

endpackage

[hdl/exlex_step.sv]
// Next-state and token logic for one character or end-of-text request.
module exlex_step #(
   parameter int POS_WIDTH = exlex_pkg::POS_WIDTH_DEFAULT
) (
   input  exlex_pkg::req_type    req,
   input  logic [2:0]            mode,
   input  logic [POS_WIDTH-1:0]  start_pos,
   input  logic [POS_WIDTH-1:0]  cur_pos,
   output logic [2:0]            mode_next,
   output logic [POS_WIDTH-1:0]  start_next,
   output logic [POS_WIDTH-1:0]  cur_next,
   output exlex_pkg::push_type   push
);
   import exlex_pkg::*;

   logic [2:0]           mode_v;
   logic                 consumed;
   logic                 a_valid;
   logic [3:0]           a_kind;
   logic [POS_WIDTH-1:0] a_start;
   logic [POS_WIDTH-1:0] a_len;
   logic                 b_valid;
   logic [3:0]           b_kind;
   logic [POS_WIDTH-1:0] b_start;
   logic [POS_WIDTH-1:0] b_len;
   logic [OUT_W-1:0]     a_start_o;
   logic [OUT_W-1:0]     a_len_o;
   logic [OUT_W-1:0]     b_start_o;
   logic [OUT_W-1:0]     b_len_o;
   rsp_type              a_rsp;
   rsp_type              b_rsp;

   always_comb begin
      mode_v     = (mode > MODE_EQ) ? MODE_IDLE : mode;
      consumed   = 1'b0;
      a_valid    = 1'b0;
      a_kind     = KIND_INT;
      a_start    = start_pos;
      a_len      = cur_pos - start_pos;
      b_valid    = 1'b0;
      b_kind     = KIND_ERR;
      b_start    = cur_pos;
      b_len      = POS_WIDTH'(1);
      mode_next  = mode_v;
      start_next = start_pos;
      cur_next   = (&cur_pos) ? cur_pos : cur_pos + 1'b1;

      // kind of the pending token if it is flushed
      case (mode_v)
         MODE_FLOAT: a_kind = KIND_FLOAT;
         MODE_SYM:   a_kind = KIND_SYM;
         MODE_EQ: begin
            a_kind = KIND_ASSIGN;
            a_len  = POS_WIDTH'(1);
         end
         default:    a_kind = KIND_INT;
      endcase

      if (req.end_of_text) begin
         a_valid    = (mode_v != MODE_IDLE);
         b_valid    = 1'b1;
         b_kind     = KIND_END;
         b_len      = '0;
         mode_next  = MODE_IDLE;
         start_next = '0;
         cur_next   = '0;
      end else begin
         case (mode_v)
            MODE_INT: begin
               if (char_digit(req.ch)) begin
                  consumed = 1'b1;
               end else if (req.ch == CH_DOT) begin
                  consumed  = 1'b1;
                  mode_next = MODE_FLOAT;
               end
            end
            MODE_FLOAT: consumed = char_digit(req.ch);
            MODE_SYM:   consumed = char_letter(req.ch);
            MODE_EQ: begin
               if (req.ch == CH_EQUAL) begin
                  consumed  = 1'b1;
                  a_valid   = 1'b1;
                  a_kind    = KIND_EQ;
                  a_len     = POS_WIDTH'(2);
                  mode_next = MODE_IDLE;
               end
            end
            default: consumed = 1'b0;
         endcase

         if (!consumed) begin
            // flush the pending token, then lex the character from idle
            a_valid   = (mode_v != MODE_IDLE);
            mode_next = MODE_IDLE;
            if (req.ch == CH_SPACE) begin
               b_valid = 1'b0;
            end else if (char_digit(req.ch)) begin
               mode_next  = MODE_INT;
               start_next = cur_pos;
            end else if (char_letter(req.ch)) begin
               mode_next  = MODE_SYM;
               start_next = cur_pos;
            end else if (req.ch == CH_EQUAL) begin
               mode_next  = MODE_EQ;
               start_next = cur_pos;
            end else begin
               b_valid = 1'b1;
               b_kind  = op_kind(req.ch);
            end
         end
      end
   end

   // clamp positions and lengths to the result field width
   if (POS_WIDTH > OUT_W) begin : g_sat
      assign a_start_o = (|a_start[POS_WIDTH-1:OUT_W]) ? '1 : a_start[OUT_W-1:0];
      assign a_len_o   = (|a_len[POS_WIDTH-1:OUT_W])   ? '1 : a_len[OUT_W-1:0];
      assign b_start_o = (|b_start[POS_WIDTH-1:OUT_W]) ? '1 : b_start[OUT_W-1:0];
      assign b_len_o   = (|b_len[POS_WIDTH-1:OUT_W])   ? '1 : b_len[OUT_W-1:0];
   end else begin : g_ext
      assign a_start_o = OUT_W'(a_start);
      assign a_len_o   = OUT_W'(a_len);
      assign b_start_o = OUT_W'(b_start);
      assign b_len_o   = OUT_W'(b_len);
   end

   always_comb begin
      a_rsp.token_kind   = a_kind;
      a_rsp.token_start  = a_start_o;
      a_rsp.token_length = a_len_o;
      a_rsp.last_of_run  = !b_valid;
      b_rsp.token_kind   = b_kind;
      b_rsp.token_start  = b_start_o;
      b_rsp.token_length = b_len_o;
      b_rsp.last_of_run  = 1'b1;

      push.count  = {1'b0, a_valid} + {1'b0, b_valid};
      push.first  = a_valid ? a_rsp : b_rsp;
      push.second = b_rsp;
   end

endmodule

[hdl/exlex_out_fifo.sv]
// Result buffer: up to two tokens in a cycle, one out unless stalled.
module exlex_out_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_en,
   input  exlex_pkg::push_type push,
   output logic                room,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output exlex_pkg::rsp_type  rsp_payload
);
   import exlex_pkg::*;

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   rsp_type              mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff;
   logic [PTR_W-1:0]     wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff;
   logic [PTR_W-1:0]     rd_ptr_in;
   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     count_in;
   logic [1:0]           push_n;
   logic                 pop;

   assign push_n      = push_en ? push.count : 2'd0;
   assign pop         = rsp_valid && !rsp_stall;
   assign rsp_valid   = (count_ff != '0);
   assign rsp_payload = mem_ff[rd_ptr_ff];
   // need space for two tokens before taking a request
   assign room        = (count_ff <= CNT_W'(FIFO_DEPTH - 2));

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push_n);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + CNT_W'(push_n) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push_n == 2'd2) begin
         mem_ff[wr_ptr_ff + PTR_W'(1)] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[hdl/expression_lexer_core.sv]
// A request is accepted, one character per cycle, while the result buffer has room
// for two tokens. Every token reaches rsp through the four-entry result buffer, and
// the single result port drains a request giving two tokens one token at a time.
// Reset (synchronous) puts the lexer in idle with both positions at zero and
// empties the result buffer; no clearing pass is needed.
module expression_lexer_core #(
   parameter int POS_WIDTH = exlex_pkg::POS_WIDTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  exlex_pkg::req_type req_payload,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output exlex_pkg::rsp_type rsp_payload
);
   import exlex_pkg::*;

   logic [2:0]           lex_mode_ff;
   logic [2:0]           lex_mode_in;
   logic [POS_WIDTH-1:0] start_pos_ff;
   logic [POS_WIDTH-1:0] start_pos_in;
   logic [POS_WIDTH-1:0] cur_pos_ff;
   logic [POS_WIDTH-1:0] cur_pos_in;
   push_type             push;
   logic                 room;
   logic                 accept;

   assign req_stall = !room;
   assign accept    = req_valid && room;

   exlex_step #(
      .POS_WIDTH(POS_WIDTH)
   ) u_step (
      .req        (req_payload),
      .mode       (lex_mode_ff),
      .start_pos  (start_pos_ff),
      .cur_pos    (cur_pos_ff),
      .mode_next  (lex_mode_in),
      .start_next (start_pos_in),
      .cur_next   (cur_pos_in),
      .push       (push)
   );

   exlex_out_fifo u_out (
      .clock       (clock),
      .reset       (reset),
      .push_en     (accept),
      .push        (push),
      .room        (room),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         lex_mode_ff  <= MODE_IDLE;
         start_pos_ff <= '0;
         cur_pos_ff   <= '0;
      end else if (accept) begin
         lex_mode_ff  <= lex_mode_in;
         start_pos_ff <= start_pos_in;
         cur_pos_ff   <= cur_pos_in;
      end
   end

endmodule
